// ===== hw/rtl/lruc_pkg.sv =====
// ----------------------------------------------------------------------------
// lruc_pkg: shared types and constants for the LRU cache core
// Sizes of the entry store, command codes and the scan result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lruc_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int RANK_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_W    = RANK_W;

  typedef enum logic {
    CMD_FIND   = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] match_idx;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] victim_idx;
  } scan_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lruc_scan.sv =====
// ----------------------------------------------------------------------------
// lruc_scan: associative key search over all entries
// Finds the matching entry, the lowest free entry and the LRU victim.
// ----------------------------------------------------------------------------
`default_nettype none

module lruc_scan (
  input  logic [lruc_pkg::CAPACITY-1:0] entry_valid,
  input  logic [lruc_pkg::KEY_W-1:0]    entry_key [lruc_pkg::CAPACITY],
  input  logic [lruc_pkg::RANK_W-1:0]   entry_rank [lruc_pkg::CAPACITY],
  input  logic [lruc_pkg::KEY_W-1:0]    key,
  output lruc_pkg::scan_t               scan
);
  import lruc_pkg::*;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(CAPACITY - 1);

  always_comb begin
    scan = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_key[i] == key)) begin
        scan.hit       = 1'b1;
        scan.match_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        scan.have_free = 1'b1;
        scan.free_idx  = IDX_W'(i);
      end
      if (entry_rank[i] == RANK_MAX) begin
        scan.victim_idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_cache_lookup_insert_core.sv =====
// ----------------------------------------------------------------------------
// lru_cache_lookup_insert_core: fully associative key-value cache, LRU
// Find and insert requests against a small cache with recency ranks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, key and value. cmd find
//   looks up key; cmd insert writes value under key: into its own entry on
//   a hit, else the lowest free entry, else the least recently used one.
//   Output channel (out_valid/out_stall) returns one result per request:
//   hit (key present before the request) and value_out (stored value on a
//   find hit, zero otherwise).
//   Results pass through an input register and a result register.
//   Throughput: one request per cycle while the receiver does not stall;
//   all entries are compared and ranks updated between the two registers.
//   Reset (rst, synchronous) clears all valid bits and ranks at once; the
//   cache is empty and ready in the first cycle after reset.
//   When the receiver stalls, the result register holds, one more request
//   waits in the input register, and in_stall rises after that.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_lookup_insert_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [63:0]                 key,
  input  logic [31:0]                 value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [31:0]                 value_out
);
  import lruc_pkg::*;

  logic                    req_valid;
  cmd_t                    req_cmd;
  logic [KEY_W-1:0]        req_key;
  logic [VAL_W-1:0]        req_value;

  logic [CAPACITY-1:0]     entry_valid;
  logic [KEY_W-1:0]        entry_key  [CAPACITY];
  logic [VAL_W-1:0]        entry_data [CAPACITY];
  logic [RANK_W-1:0]       entry_rank [CAPACITY];
  logic [RANK_W-1:0]       entry_rank_next [CAPACITY];

  scan_t                   scan;
  logic                    advance;
  logic                    upd;
  logic                    write_kv;
  logic [IDX_W-1:0]        tgt_idx;
  logic [RANK_W:0]         r_lim;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = req_valid && !advance;

  lruc_scan u_scan (
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_rank  (entry_rank),
    .key         (req_key),
    .scan        (scan)
  );

  always_comb begin
    priority if (scan.hit) begin
      tgt_idx = scan.match_idx;
      r_lim   = {1'b0, entry_rank[scan.match_idx]};
    end else if (scan.have_free) begin
      tgt_idx = scan.free_idx;
      r_lim   = (RANK_W + 1)'(CAPACITY);
    end else begin
      tgt_idx = scan.victim_idx;
      r_lim   = {1'b0, entry_rank[scan.victim_idx]};
    end
    upd      = advance && req_valid && (scan.hit || (req_cmd == CMD_INSERT));
    write_kv = advance && req_valid && (req_cmd == CMD_INSERT);
    for (int i = 0; i < CAPACITY; i++) begin
      entry_rank_next[i] = entry_rank[i];
      if (entry_valid[i] && ({1'b0, entry_rank[i]} < r_lim)) begin
        entry_rank_next[i] = entry_rank[i] + 1'b1;
      end
    end
    entry_rank_next[tgt_idx] = '0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
    if (!in_stall) begin
      req_cmd   <= cmd_t'(cmd);
      req_key   <= key[KEY_W-1:0];
      req_value <= value[VAL_W-1:0];
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        entry_rank[i] <= '0;
      end
    end else if (upd) begin
      entry_valid[tgt_idx] <= 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
        entry_rank[i] <= entry_rank_next[i];
      end
    end
    if (write_kv) begin
      entry_key[tgt_idx]  <= req_key;
      entry_data[tgt_idx] <= req_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
    if (advance && req_valid) begin
      hit <= scan.hit;
      if (scan.hit && (req_cmd == CMD_FIND)) begin
        value_out <= entry_data[scan.match_idx];
      end else begin
        value_out <= '0;
      end
    end
  end

  logic [CAPACITY-1:0] rank_zero_vec;
  logic [CAPACITY-1:0] rank_max_vec;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      rank_zero_vec[i] = entry_valid[i] && (entry_rank[i] == '0);
      rank_max_vec[i]  = entry_valid[i] && (entry_rank[i] == RANK_W'(CAPACITY - 1));
    end
  end

  a_stall_has_req: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid)
    else $error("in_stall without a held request");

  a_req_to_result: assert property (@(posedge clk) disable iff (rst)
    (advance && req_valid) |=> out_valid)
    else $error("processed request produced no result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (value_out == '0))
    else $error("miss result carries nonzero value");

  a_one_mru: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rank_zero_vec))
    else $error("more than one most recent entry");

  a_one_lru_when_full: assert property (@(posedge clk) disable iff (rst)
    (&entry_valid) |-> $onehot(rank_max_vec))
    else $error("full cache without a unique LRU entry");

endmodule

`default_nettype wire
